// ===== design/temperature_window_statistics_defines.svh =====
// Assertion macros used by the checker file of this block.
`ifndef TEMPERATURE_WINDOW_STATISTICS_DEFINES_SVH
`define TEMPERATURE_WINDOW_STATISTICS_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TWS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TWS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/twstat_pkg.sv =====
package twstat_pkg;

  // Fixed field widths.
  localparam int TEMP_W  = 16;
  localparam int THR_W   = 15;
  localparam int COUNT_W = 7;
  localparam int STD_W   = 15;

  // Default window depth and threshold after reset.
  localparam int              WINDOW_SIZE_DEF = 10;
  localparam logic [THR_W-1:0] THR_RESET      = 15'd3300;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  // Input transaction.
  typedef struct packed {
    kind_t                    kind;
    logic signed [TEMP_W-1:0] temperature;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic                     sample_taken;
    logic                     above_threshold;
    logic                     running;
    logic                     window_empty;
    logic [COUNT_W-1:0]       sample_count;
    logic signed [TEMP_W-1:0] mean_value;
    logic signed [TEMP_W-1:0] min_value;
    logic signed [TEMP_W-1:0] max_value;
    logic [STD_W-1:0]         std_dev;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_DRAIN,
    ST_PROD,
    ST_DIFF,
    ST_ROOT,
    ST_DIVSTD,
    ST_DONE
  } state_t;

  // Accumulator control.
  typedef struct packed {
    logic clear;
    logic enable;
  } acc_ctl_t;

endpackage

// ===== design/twstat_cell.sv =====
module twstat_cell (
  input  logic                                 clk,
  input  logic                                 shift_en,
  input  logic signed [twstat_pkg::TEMP_W-1:0] d,
  output logic signed [twstat_pkg::TEMP_W-1:0] q
);

  logic signed [twstat_pkg::TEMP_W-1:0] val_r;

  // One window entry; it takes its neighbour's value whenever the chain moves.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

// ===== design/twstat_accum.sv =====
module twstat_accum #(
  parameter int CNT_W = 4
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  twstat_pkg::acc_ctl_t                          ctl,
  input  logic signed [twstat_pkg::TEMP_W-1:0]          value,
  output logic signed [twstat_pkg::TEMP_W+CNT_W-1:0]    sum,
  output logic [2*twstat_pkg::TEMP_W-1+CNT_W-1:0]       sum_sq,
  output logic signed [twstat_pkg::TEMP_W-1:0]          min_val,
  output logic signed [twstat_pkg::TEMP_W-1:0]          max_val
);

  localparam int TW   = twstat_pkg::TEMP_W;
  localparam int S1_W = TW + CNT_W;
  localparam int SQ_W = 2 * TW - 1;
  localparam int S2_W = SQ_W + CNT_W;

  logic signed [2*TW-1:0] prod;
  logic                   a_vld_r;
  logic signed [TW-1:0]   a_val_r;
  logic [SQ_W-1:0]        a_sq_r;
  logic                   have_r;
  logic signed [S1_W-1:0] s1_r;
  logic [S2_W-1:0]        s2_r;
  logic signed [TW-1:0]   min_r;
  logic signed [TW-1:0]   max_r;

  // The square of a 16-bit sample never exceeds 2^30, so 31 bits hold it.
  assign prod = value * value;

  // First stage: register the sample and its square.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= ctl.enable;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.enable) begin
      a_val_r <= value;
      a_sq_r  <= prod[SQ_W-1:0];
    end
  end

  // Second stage: running sums and extremes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (ctl.clear) begin
      have_r <= 1'b0;
    end else if (a_vld_r) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (a_vld_r) begin
      s1_r <= s1_r + S1_W'(a_val_r);
      s2_r <= s2_r + S2_W'(a_sq_r);
      if (!have_r || (a_val_r < min_r)) begin
        min_r <= a_val_r;
      end
      if (!have_r || (a_val_r > max_r)) begin
        max_r <= a_val_r;
      end
    end
  end

  assign sum     = s1_r;
  assign sum_sq  = s2_r;
  assign min_val = min_r;
  assign max_val = max_r;

endmodule

// ===== design/twstat_isqrt.sv =====
module twstat_isqrt #(
  parameter int RT_W = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2*RT_W-1:0] radicand,
  output logic              busy,
  output logic [RT_W-1:0]   root
);

  localparam int CW = $clog2(RT_W + 1);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [2*RT_W-1:0] x_r;
  logic [RT_W+1:0]   rem_r;
  logic [RT_W-1:0]   root_r;
  logic [RT_W+1:0]   rem_sh;
  logic [RT_W+1:0]   trial;
  logic              ge;

  // One result bit per cycle: bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem_r[RT_W-1:0], x_r[2*RT_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(RT_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[2*RT_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[RT_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== design/twstat_div.sv =====
module twstat_div #(
  parameter int DV_W = 20,
  parameter int DS_W = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DV_W-1:0] dividend,
  input  logic [DS_W-1:0] divisor,
  output logic            busy,
  output logic [DV_W-1:0] quotient
);

  localparam int CW = $clog2(DV_W + 1);

  logic            busy_r;
  logic [CW-1:0]   cnt_r;
  logic [DV_W-1:0] q_r;
  logic [DS_W-1:0] rem_r;
  logic [DS_W-1:0] d_r;
  logic [DS_W:0]   rem_sh;
  logic [DS_W:0]   diff;
  logic            ge;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_r, q_r[DV_W-1]};
  assign diff   = rem_sh - {1'b0, d_r};
  assign ge     = (rem_sh >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DV_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DV_W-2:0], ge};
      rem_r <= ge ? diff[DS_W-1:0] : rem_sh[DS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ===== design/temperature_window_statistics.sv =====
// Sliding-window temperature statistics.
// Input channel in_valid/in_stall/in_data carries one item: a sample, a start
// (clears the window and sets running), a stop, or a statistics query. Every
// item gives exactly one result on out_valid/out_stall/out_data. The alarm
// threshold is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high.
// Sample, start and stop items finish in the cycle they are accepted and their
// result is presented on the next cycle. A query on a non-empty window rotates
// the row of window cells once, then runs an iterative square root and a
// shared iterative divider, one bit per cycle each; the next item is taken
// once its result has been loaded into the output register.
// Synchronous reset (rst_n low) empties the window, clears the running flag
// and the output valid flag, and restores the threshold to 33.00 degrees.
// While the receiver stalls, the result is held; a query may still be accepted
// and worked on, but other items wait until the output register is free.
module temperature_window_statistics #(
  parameter int WINDOW_SIZE = twstat_pkg::WINDOW_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  twstat_pkg::in_item_t         in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output twstat_pkg::out_item_t        out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [twstat_pkg::THR_W-1:0] cfg_data
);

  localparam int TW     = twstat_pkg::TEMP_W;
  localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
  localparam int S1_W   = TW + CNT_W;
  localparam int SQ_W   = 2 * TW - 1;
  localparam int S2_W   = SQ_W + CNT_W;
  localparam int DISC_W = S2_W + CNT_W;
  localparam int RT_W   = S1_W;
  localparam int S1SQ_W = 2 * S1_W;
  localparam logic [CNT_W-1:0] W_CNT  = CNT_W'(WINDOW_SIZE);
  localparam logic [CNT_W-1:0] W_LAST = CNT_W'(WINDOW_SIZE - 1);

  twstat_pkg::state_t   state_r;
  twstat_pkg::state_t   state_nxt;
  twstat_pkg::acc_ctl_t acc_ctl;
  twstat_pkg::out_item_t out_r;
  twstat_pkg::out_item_t res;

  logic                         run_r;
  logic                         run_nxt;
  logic [CNT_W-1:0]             cnt_r;
  logic [CNT_W-1:0]             cnt_nxt;
  logic [twstat_pkg::THR_W-1:0] thr_r;
  logic [CNT_W-1:0]             rot_r;
  logic                         out_valid_r;
  logic signed [TW-1:0]         mean_r;
  logic [DISC_W-1:0]            ns2_r;
  logic [S1SQ_W-1:0]            s1sq_r;

  logic                 in_acc;
  logic                 is_query;
  logic                 out_free;
  logic                 chain_shift;
  logic signed [TW-1:0] chain_in;
  logic signed [TW-1:0] cell_q [WINDOW_SIZE];
  logic signed [TW-1:0] cell_d [WINDOW_SIZE];
  logic                 tap_valid;
  logic                 units_idle;
  logic                 sq_start;
  logic                 dv_start;
  logic                 mean_load;
  logic                 out_load;
  logic                 stored;
  logic                 above;
  logic signed [TW:0]   temp_x;
  logic signed [TW:0]   thr_x;

  logic signed [S1_W-1:0]   s1_acc;
  logic [S2_W-1:0]          s2_acc;
  logic signed [TW-1:0]     min_acc;
  logic signed [TW-1:0]     max_acc;
  logic [DISC_W-1:0]        ns2_full;
  logic signed [S1SQ_W-1:0] s1sq_full;
  logic [S1SQ_W-1:0]        disc_full;
  logic [2*RT_W-1:0]        radicand;
  logic                     s1_neg;
  logic [S1_W-1:0]          s1_mag;
  logic [S1_W-1:0]          dv_dividend;
  logic                     sq_busy;
  logic [RT_W-1:0]          sq_root;
  logic                     dv_busy;
  logic [S1_W-1:0]          dv_quot;
  logic [S1_W-1:0]          mean_s;

  // Handshake.
  assign is_query  = (in_data.kind == twstat_pkg::KIND_QUERY);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != twstat_pkg::ST_IDLE) ||
                     (out_valid_r && out_stall && !is_query);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Run flag and fill count after a simple item.
  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    case (in_data.kind)
      twstat_pkg::KIND_SAMPLE: begin
        if (run_r && (cnt_r != W_CNT)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      twstat_pkg::KIND_START: begin
        run_nxt = 1'b1;
        cnt_nxt = '0;
      end
      twstat_pkg::KIND_STOP: begin
        run_nxt = 1'b0;
      end
      default: begin
        run_nxt = run_r;
      end
    endcase
  end

  // Row of window cells: new samples enter at the head, a query rotates the row.
  assign chain_in = (state_r == twstat_pkg::ST_ROTATE) ? cell_q[WINDOW_SIZE-1]
                                                       : in_data.temperature;

  for (genvar g = 0; g < WINDOW_SIZE; g++) begin : g_chain
    if (g == 0) begin : g_head
      assign cell_d[g] = chain_in;
    end else begin : g_body
      assign cell_d[g] = cell_q[g-1];
    end
    twstat_cell u_cell (
      .clk      (clk),
      .shift_en (chain_shift),
      .d        (cell_d[g]),
      .q        (cell_q[g])
    );
  end

  // The tail cell holds a filled entry only in the last cnt_r rotation steps.
  assign tap_valid = (rot_r >= (W_CNT - cnt_r));

  twstat_accum #(
    .CNT_W (CNT_W)
  ) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (acc_ctl),
    .value   (cell_q[WINDOW_SIZE-1]),
    .sum     (s1_acc),
    .sum_sq  (s2_acc),
    .min_val (min_acc),
    .max_val (max_acc)
  );

  // Discriminant n*S2 - S1^2, products registered before the subtraction.
  assign ns2_full  = cnt_r * s2_acc;
  assign s1sq_full = s1_acc * s1_acc;
  assign disc_full = S1SQ_W'(ns2_r) - s1sq_r;
  assign radicand  = (2*RT_W)'(disc_full[DISC_W-1:0]);

  always_ff @(posedge clk) begin
    ns2_r  <= ns2_full;
    s1sq_r <= $unsigned(s1sq_full);
  end

  twstat_isqrt #(
    .RT_W (RT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .busy     (sq_busy),
    .root     (sq_root)
  );

  // Shared divider: first the mean magnitude, then the root over the count.
  assign s1_neg      = s1_acc[S1_W-1];
  assign s1_mag      = s1_neg ? $unsigned(-s1_acc) : $unsigned(s1_acc);
  assign dv_dividend = (state_r == twstat_pkg::ST_ROOT) ? sq_root : s1_mag;

  twstat_div #(
    .DV_W (S1_W),
    .DS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (cnt_r),
    .busy     (dv_busy),
    .quotient (dv_quot)
  );

  assign units_idle = !sq_busy && !dv_busy;
  assign mean_s     = s1_neg ? (~dv_quot + 1'b1) : dv_quot;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      twstat_pkg::ST_IDLE: begin
        if (in_acc && is_query) begin
          state_nxt = (cnt_r == '0) ? twstat_pkg::ST_DONE : twstat_pkg::ST_ROTATE;
        end
      end
      twstat_pkg::ST_ROTATE: begin
        if (rot_r == W_LAST) begin
          state_nxt = twstat_pkg::ST_DRAIN;
        end
      end
      twstat_pkg::ST_DRAIN:  state_nxt = twstat_pkg::ST_PROD;
      twstat_pkg::ST_PROD:   state_nxt = twstat_pkg::ST_DIFF;
      twstat_pkg::ST_DIFF:   state_nxt = twstat_pkg::ST_ROOT;
      twstat_pkg::ST_ROOT: begin
        if (units_idle) begin
          state_nxt = twstat_pkg::ST_DIVSTD;
        end
      end
      twstat_pkg::ST_DIVSTD: begin
        if (!dv_busy) begin
          state_nxt = twstat_pkg::ST_DONE;
        end
      end
      twstat_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = twstat_pkg::ST_IDLE;
        end
      end
      default: state_nxt = twstat_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    chain_shift    = 1'b0;
    acc_ctl.clear  = 1'b0;
    acc_ctl.enable = 1'b0;
    sq_start       = 1'b0;
    dv_start       = 1'b0;
    mean_load      = 1'b0;
    out_load       = 1'b0;
    case (state_r)
      twstat_pkg::ST_IDLE: begin
        chain_shift   = in_acc && run_r && (in_data.kind == twstat_pkg::KIND_SAMPLE);
        acc_ctl.clear = in_acc && is_query;
        out_load      = in_acc && !is_query;
      end
      twstat_pkg::ST_ROTATE: begin
        chain_shift    = 1'b1;
        acc_ctl.enable = tap_valid;
      end
      twstat_pkg::ST_DIFF: begin
        sq_start = 1'b1;
        dv_start = 1'b1;
      end
      twstat_pkg::ST_ROOT: begin
        dv_start  = units_idle;
        mean_load = units_idle;
      end
      twstat_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: begin
        chain_shift = 1'b0;
      end
    endcase
  end

  // Alarm compare on a 17-bit signed scale.
  assign temp_x = {in_data.temperature[TW-1], in_data.temperature};
  assign thr_x  = {2'b00, thr_r};
  assign stored = run_r && (in_data.kind == twstat_pkg::KIND_SAMPLE);
  assign above  = stored && (temp_x > thr_x);

  // Result assembly.
  always_comb begin
    res = '0;
    if (state_r == twstat_pkg::ST_DONE) begin
      res.running      = run_r;
      res.sample_count = twstat_pkg::COUNT_W'(cnt_r);
      if (cnt_r == '0) begin
        res.window_empty = 1'b1;
      end else begin
        res.mean_value = mean_r;
        res.min_value  = min_acc;
        res.max_value  = max_acc;
        res.std_dev    = dv_quot[twstat_pkg::STD_W-1:0];
      end
    end else begin
      res.sample_taken    = stored;
      res.above_threshold = above;
      res.running         = run_nxt;
      res.sample_count    = twstat_pkg::COUNT_W'(cnt_nxt);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= twstat_pkg::ST_IDLE;
      run_r       <= 1'b0;
      cnt_r       <= '0;
      thr_r       <= twstat_pkg::THR_RESET;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (in_acc && !is_query) begin
        run_r <= run_nxt;
        cnt_r <= cnt_nxt;
      end
      if (state_r == twstat_pkg::ST_ROTATE) begin
        rot_r <= rot_r + 1'b1;
      end else begin
        rot_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (mean_load) begin
      mean_r <= mean_s[TW-1:0];
    end
    if (out_load) begin
      out_r <= res;
    end
  end

endmodule

// ===== design/twstat_checker.sv =====
`include "temperature_window_statistics_defines.svh"

module twstat_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input twstat_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input twstat_pkg::out_item_t out_data
);

  // A stalled result stays on the port unchanged.
  `TWS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // Sample, start and stop transactions answer on the following cycle.
  `TWS_ASSERT_NXT(a_quick_result, clk, rst_n, in_valid && !in_stall && (in_data.kind != twstat_pkg::KIND_QUERY), out_valid, "no result after a simple transaction")

  // An empty window reports no samples and stores none.
  `TWS_ASSERT_IMP(a_empty_count, clk, rst_n, out_valid && out_data.window_empty, (out_data.sample_count == '0) && !out_data.sample_taken, "empty flag with samples")

  // The minimum never lies above the maximum.
  `TWS_ASSERT_IMP(a_min_max, clk, rst_n, out_valid && (out_data.sample_count != '0), out_data.min_value <= out_data.max_value, "minimum above maximum")

endmodule

bind temperature_window_statistics twstat_checker u_twstat_checker (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;

  localparam int WIN_DEPTH = twstat_pkg::WINDOW_SIZE_DEF;

  // Clock and block inputs, all at known values from time zero.
  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         in_valid  = 1'b0;
  twstat_pkg::in_item_t         in_data   = '0;
  logic                         out_stall = 1'b0;
  logic                         cfg_valid = 1'b0;
  logic [twstat_pkg::THR_W-1:0] cfg_data  = '0;
  logic                         in_stall;
  logic                         out_valid;
  twstat_pkg::out_item_t        out_data;
  logic                         cfg_ready;

  // Window state as the testbench expects it to be.
  logic signed [twstat_pkg::TEMP_W-1:0] win_cells [WIN_DEPTH];
  int                                   win_wr_ptr  = 0;
  int                                   win_fill    = 0;
  logic                                 win_running = 1'b0;
  logic [twstat_pkg::THR_W-1:0]         alarm_thr   = twstat_pkg::THR_RESET;

  // Results still owed by the block, oldest first.
  twstat_pkg::out_item_t expected_results [$];

  int   mismatches  = 0;
  int   items_sent  = 0;
  int   stall_left  = 0;
  logic tx_idle_en  = 1'b1;
  logic rx_idle_en  = 1'b1;
  logic quiet       = 1'b0;

  temperature_window_statistics DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Floor of the square root, one result bit per pass.
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Applies one input transaction to the expected window state and returns
  // the result it should produce.
  function automatic twstat_pkg::out_item_t predict_window(twstat_pkg::in_item_t it);
    twstat_pkg::out_item_t r;
    longint                s1;
    longint                s2;
    longint                q;
    longint unsigned       disc;
    longint unsigned       root;
    int                    n;
    int                    lo;
    int                    hi;
    int                    v;
    int                    t;
    int                    i;
    r = '0;
    t = it.temperature;
    case (it.kind)
      twstat_pkg::KIND_SAMPLE: begin
        if (win_running) begin
          win_cells[win_wr_ptr] = it.temperature;
          win_wr_ptr = (win_wr_ptr + 1) % WIN_DEPTH;
          if (win_fill < WIN_DEPTH) win_fill++;
          r.sample_taken    = 1'b1;
          r.above_threshold = (t > int'(alarm_thr));
        end
      end
      twstat_pkg::KIND_START: begin
        for (i = 0; i < WIN_DEPTH; i++) win_cells[i] = '0;
        win_wr_ptr  = 0;
        win_fill    = 0;
        win_running = 1'b1;
      end
      twstat_pkg::KIND_STOP: begin
        win_running = 1'b0;
      end
      default: begin
        n = win_fill;
        if (n == 0) begin
          r.window_empty = 1'b1;
        end else begin
          s1 = 0;
          s2 = 0;
          lo = win_cells[0];
          hi = lo;
          for (i = 0; i < n; i++) begin
            v = win_cells[i];
            if (v < lo) lo = v;
            if (v > hi) hi = v;
            s1 = s1 + v;
            s2 = s2 + longint'(v) * v;
          end
          q    = s1 / n;
          disc = longint'(n) * s2 - s1 * s1;
          root = root_floor(disc) / longint'(n);
          r.mean_value = q[15:0];
          r.min_value  = 16'(lo);
          r.max_value  = 16'(hi);
          r.std_dev    = root[14:0];
        end
      end
    endcase
    r.running      = win_running;
    r.sample_count = 7'(win_fill);
    return r;
  endfunction

  // Sample values biased towards the range ends and the alarm threshold.
  function automatic logic signed [twstat_pkg::TEMP_W-1:0] pick_temperature();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3:    return 16'(int'(alarm_thr) + int'($urandom_range(0, 2)) - 1);
      4:       return 16'(int'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic compare_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(twstat_pkg::out_item_t got);
    twstat_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: result with nothing expected, actual %p", $time, got);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      compare_field("sample_taken",    want.sample_taken,    got.sample_taken);
      compare_field("above_threshold", want.above_threshold, got.above_threshold);
      compare_field("running",         want.running,         got.running);
      compare_field("window_empty",    want.window_empty,    got.window_empty);
      compare_field("sample_count",    want.sample_count,    got.sample_count);
      compare_field("mean_value",      want.mean_value,      got.mean_value);
      compare_field("min_value",       want.min_value,       got.min_value);
      compare_field("max_value",       want.max_value,       got.max_value);
      compare_field("std_dev",         want.std_dev,         got.std_dev);
    end
  endtask

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) compare_result(out_data);
  end

  // Receiver back-pressure in random bursts.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Sends one input transaction, with an optional gap before it, and records
  // the result it should produce once it has been accepted.
  task automatic drive_item(twstat_pkg::kind_t k,
                            logic signed [twstat_pkg::TEMP_W-1:0] temp);
    twstat_pkg::in_item_t it;
    it.kind        = k;
    it.temperature = temp;
    if (!(k == twstat_pkg::KIND_SAMPLE && !win_running)) items_sent++;
    if (tx_idle_en && !quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_window(it));
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // The threshold is only rewritten once the block has nothing in flight.
  task automatic write_threshold(logic [twstat_pkg::THR_W-1:0] value);
    wait_until_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    alarm_thr = value;
  endtask

  // Mostly well-formed runs (start, samples, queries, sometimes a stop),
  // with some random noise and some windows filled with range extremes.
  task automatic run_random_sequences(int n_items);
    int first;
    int pick;
    int k;
    int i;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if (!quiet) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = tx_idle_en;
      end
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        drive_item(twstat_pkg::KIND_START, 16'($urandom));
        k = $urandom_range(0, 14);
        for (i = 0; i < k; i++) begin
          drive_item(twstat_pkg::KIND_SAMPLE, pick_temperature());
          if ($urandom_range(0, 3) == 0) begin
            drive_item(twstat_pkg::KIND_QUERY, 16'($urandom));
          end
        end
        drive_item(twstat_pkg::KIND_QUERY, 16'($urandom));
        if ($urandom_range(0, 2) == 0) begin
          drive_item(twstat_pkg::KIND_STOP, 16'($urandom));
          drive_item(twstat_pkg::KIND_SAMPLE, pick_temperature());
          drive_item(twstat_pkg::KIND_QUERY, 16'($urandom));
        end
      end else if (pick < 17) begin
        k = $urandom_range(1, 6);
        for (i = 0; i < k; i++) begin
          drive_item(twstat_pkg::kind_t'($urandom_range(0, 3)), 16'($urandom));
        end
      end else begin
        drive_item(twstat_pkg::KIND_START, 16'($urandom));
        k = $urandom_range(10, 13);
        for (i = 0; i < k; i++) begin
          drive_item(twstat_pkg::KIND_SAMPLE,
                     ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000);
        end
        drive_item(twstat_pkg::KIND_QUERY, 16'($urandom));
      end
    end
  endtask

  // Empty and stopped windows, range extremes, the threshold boundary,
  // wrap-around of a full window, restart while running and a stopped query.
  task automatic test_basic_sequence();
    drive_item(twstat_pkg::KIND_QUERY,  16'sd0);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sd1000);
    drive_item(twstat_pkg::KIND_STOP,   16'sd0);
    drive_item(twstat_pkg::KIND_START,  16'sd0);
    drive_item(twstat_pkg::KIND_QUERY,  16'sd0);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sh8000);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sh7FFF);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sd3300);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sd3301);
    drive_item(twstat_pkg::KIND_QUERY,  16'sd0);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sd0);
    drive_item(twstat_pkg::KIND_SAMPLE, -16'sd1);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sd1);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sd100);
    drive_item(twstat_pkg::KIND_SAMPLE, -16'sd100);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sd12345);
    drive_item(twstat_pkg::KIND_SAMPLE, -16'sd12345);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sd3299);
    drive_item(twstat_pkg::KIND_QUERY,  16'sd0);
    drive_item(twstat_pkg::KIND_START,  16'sd0);
    drive_item(twstat_pkg::KIND_SAMPLE, -16'sd5);
    drive_item(twstat_pkg::KIND_STOP,   16'sd0);
    drive_item(twstat_pkg::KIND_SAMPLE, 16'sd7);
    drive_item(twstat_pkg::KIND_QUERY,  16'sd0);
  endtask

  task automatic test_reset_threshold();
    run_random_sequences(150);
  endtask

  // Zero, the smallest positive and the largest threshold.
  task automatic test_threshold_extremes();
    write_threshold(15'd0);
    run_random_sequences(80);
    write_threshold(15'd1);
    run_random_sequences(80);
    write_threshold(15'h7FFF);
    run_random_sequences(80);
  endtask

  task automatic test_random_threshold();
    repeat (2) begin
      write_threshold(15'($urandom_range(1, 32767)));
      run_random_sequences(80);
    end
  endtask

  // Final stretch at full rate with no idling on either side.
  task automatic test_unthrottled_tail();
    quiet      = 1'b1;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_threshold(15'($urandom_range(1, 32767)));
    run_random_sequences(100);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_sequence();
    test_reset_threshold();
    test_threshold_extremes();
    test_random_threshold();
    test_unthrottled_tail();
    wait_until_drained();
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== temperature_window_statistics.f =====
+incdir+design
design/twstat_pkg.sv
design/twstat_cell.sv
design/twstat_accum.sv
design/twstat_isqrt.sv
design/twstat_div.sv
design/temperature_window_statistics.sv
design/twstat_checker.sv
tb/sv/tb_top.sv
